// File: hw/rtl/gbn_pkg.sv
// ----------------------------------------------------------------------------
// gbn_pkg
// Shared types and constants for the Go-Back-N sender window controller.
// ----------------------------------------------------------------------------
package gbn_pkg;

  localparam int SEQ_W        = 16;
  localparam int LEN_W        = 13;
  localparam int KIND_W       = 3;
  localparam int SLOT_OUT_W   = 3;
  localparam int SLOT_FIELD_W = 6;   // holds a slot index for up to 64 slots
  localparam int CNT_W        = 4;
  localparam int WIN_W        = 4;
  localparam int MAX_RUN      = 8;   // most results one item can cause

  localparam int DEF_SLOTS     = 8;
  localparam int DEF_MAX_CHUNK = 8000;
  localparam int CMDQ_DEPTH    = 2;

  localparam logic [WIN_W-1:0] WIN_RESET = 4'd5;

  typedef enum logic [1:0] {
    MODE_OFFER    = 2'd0,
    MODE_ACK      = 2'd1,
    MODE_TIMEOUT  = 2'd2,
    MODE_FIN_ACK  = 2'd3
  } mode_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_REFUSED = 3'd0,
    KIND_FIRST   = 3'd1,
    KIND_DATA    = 3'd2,
    KIND_RETX    = 3'd3,
    KIND_FIN     = 3'd4,
    KIND_DONE    = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    CMD_SINGLE = 2'd0,   // one result, no slot access
    CMD_SEND   = 2'd1,   // record length in slot, one result
    CMD_RETX   = 2'd2    // walk cnt slots starting at seq/slot
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t                 op;
    kind_t                   kind;
    logic [SEQ_W-1:0]        seq;
    logic [LEN_W-1:0]        len;
    logic [SLOT_FIELD_W-1:0] slot;
    logic [CNT_W-1:0]        cnt;
  } cmd_t;

endpackage

// File: hw/rtl/go_back_n_sender_window.sv
// An accepted item is written into the command queue and then into the back end's
// output registers before strobe rises. Throughput: one item per cycle for items giving
// one result while no retransmit run is walked; a timeout emits its N retransmit results
// back to back (N up to 8), set by the single slot-memory read port walked by the back end.
// busy is high while the two-entry command queue is full.
// Reset (rst, synchronous) clears window state, queue and strobe; window 5.
// ----------------------------------------------------------------------------
// go_back_n_sender_window
// Go-Back-N sender window controller: front classifies items, a short
// command queue decouples it from the back end that issues result items.
// ----------------------------------------------------------------------------
module go_back_n_sender_window #(
  parameter int SLOTS     = gbn_pkg::DEF_SLOTS,
  parameter int MAX_CHUNK = gbn_pkg::DEF_MAX_CHUNK
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic [1:0]                       mode,
  input  logic [gbn_pkg::LEN_W-1:0]        chunk_len,
  input  logic                             end_of_data,
  input  logic [gbn_pkg::SEQ_W-1:0]        ack_seq,
  input  logic                             window_we,
  input  logic [gbn_pkg::WIN_W-1:0]        window_wdata,
  output logic                             strobe,
  output logic [gbn_pkg::KIND_W-1:0]       kind,
  output logic [gbn_pkg::SEQ_W-1:0]        seq_out,
  output logic [gbn_pkg::LEN_W-1:0]        len_out,
  output logic [gbn_pkg::SLOT_OUT_W-1:0]   slot_out,
  output logic                             last
);

  logic          q_full;
  logic          q_push;
  logic          q_pop;
  logic          q_valid;
  gbn_pkg::cmd_t push_cmd;
  gbn_pkg::cmd_t head_cmd;

  assign busy = q_full;

  gbn_front #(
    .SLOTS     (SLOTS),
    .MAX_CHUNK (MAX_CHUNK)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .q_full       (q_full),
    .mode         (mode),
    .chunk_len    (chunk_len),
    .end_of_data  (end_of_data),
    .ack_seq      (ack_seq),
    .window_we    (window_we),
    .window_wdata (window_wdata),
    .push         (q_push),
    .cmd          (push_cmd)
  );

  gbn_cmdq u_cmdq (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .full     (q_full),
    .valid    (q_valid),
    .head     (head_cmd)
  );

  gbn_back #(
    .SLOTS (SLOTS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_cmd    (head_cmd),
    .pop      (q_pop),
    .strobe   (strobe),
    .kind     (kind),
    .seq_out  (seq_out),
    .len_out  (len_out),
    .slot_out (slot_out),
    .last     (last)
  );

endmodule

// File: hw/rtl/gbn_front.sv
// ----------------------------------------------------------------------------
// gbn_front
// Accepts items, keeps the window state and turns each item into a command.
// ----------------------------------------------------------------------------
module gbn_front #(
  parameter int SLOTS     = gbn_pkg::DEF_SLOTS,
  parameter int MAX_CHUNK = gbn_pkg::DEF_MAX_CHUNK
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic                        q_full,
  input  logic [1:0]                  mode,
  input  logic [gbn_pkg::LEN_W-1:0]   chunk_len,
  input  logic                        end_of_data,
  input  logic [gbn_pkg::SEQ_W-1:0]   ack_seq,
  input  logic                        window_we,
  input  logic [gbn_pkg::WIN_W-1:0]   window_wdata,
  output logic                        push,
  output gbn_pkg::cmd_t               cmd
);

  localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int LIM   = (SLOTS < gbn_pkg::MAX_RUN) ? SLOTS : gbn_pkg::MAX_RUN;
  localparam int SUM_W = ((SW > gbn_pkg::CNT_W) ? SW : gbn_pkg::CNT_W) + 1;
  localparam logic [gbn_pkg::WIN_W-1:0] LIM_V    = gbn_pkg::WIN_W'(LIM);
  localparam logic [gbn_pkg::SEQ_W-1:0] MAX_LEN  = gbn_pkg::SEQ_W'(MAX_CHUNK);
  localparam logic [SUM_W-1:0]          SLOTS_S  = SUM_W'(SLOTS);
  localparam logic [SW-1:0]             SLOT_TOP = SW'(SLOTS - 1);

  logic [gbn_pkg::WIN_W-1:0] win_limit, win_limit_next;
  logic [gbn_pkg::SEQ_W-1:0] base_seq, base_seq_next;
  logic [gbn_pkg::SEQ_W-1:0] snd_seq, snd_seq_next;
  logic [SW-1:0]             base_slot, base_slot_next;
  logic [SW-1:0]             next_slot, next_slot_next;
  logic                      data_ended, data_ended_next;
  logic                      fin_sent, fin_sent_next;

  logic                      accept;
  logic [gbn_pkg::SEQ_W-1:0] outstanding;
  logic [gbn_pkg::WIN_W-1:0] eff_window;
  logic [gbn_pkg::LEN_W-1:0] len_sat;
  logic [gbn_pkg::SEQ_W-1:0] ack_off;
  logic [gbn_pkg::SEQ_W-1:0] ack_base;
  logic [gbn_pkg::SEQ_W-1:0] ack_step;
  logic [SUM_W-1:0]          slot_sum;
  logic [SW-1:0]             ack_slot;
  logic [gbn_pkg::SEQ_W-1:0] next_inc;
  logic [SW-1:0]             next_slot_inc;
  logic [gbn_pkg::SEQ_W-1:0] base_upd;

  assign accept = start && !q_full;

  always_comb begin
    outstanding = snd_seq - base_seq;

    if (win_limit == '0) begin
      eff_window = gbn_pkg::WIN_W'(1);
    end else if (win_limit > LIM_V) begin
      eff_window = LIM_V;
    end else begin
      eff_window = win_limit;
    end

    if (gbn_pkg::SEQ_W'(chunk_len) > MAX_LEN) begin
      len_sat = MAX_LEN[gbn_pkg::LEN_W-1:0];
    end else begin
      len_sat = chunk_len;
    end

    // ack moves base by at most the outstanding count (never above SLOTS),
    // so one conditional subtract keeps the slot in range
    ack_off  = ack_seq - base_seq;
    ack_base = ack_seq + gbn_pkg::SEQ_W'(1);
    ack_step = ack_base - base_seq;
    slot_sum = SUM_W'(base_slot) + SUM_W'(ack_step[gbn_pkg::CNT_W-1:0]);
    if (ack_base < base_seq) begin
      // sequence wrapped past zero: new base is below SLOTS
      ack_slot = ack_base[SW-1:0];
    end else if (slot_sum >= SLOTS_S) begin
      ack_slot = SW'(slot_sum - SLOTS_S);
    end else begin
      ack_slot = slot_sum[SW-1:0];
    end

    next_inc = snd_seq + gbn_pkg::SEQ_W'(1);
    if (next_inc == '0 || next_slot == SLOT_TOP) begin
      next_slot_inc = '0;
    end else begin
      next_slot_inc = next_slot + SW'(1);
    end
  end

  always_comb begin
    win_limit_next   = win_limit;
    base_seq_next    = base_seq;
    snd_seq_next     = snd_seq;
    base_slot_next   = base_slot;
    next_slot_next   = next_slot;
    data_ended_next  = data_ended;
    fin_sent_next    = fin_sent;
    base_upd         = base_seq;
    push             = 1'b0;
    cmd.op           = gbn_pkg::CMD_SINGLE;
    cmd.kind         = gbn_pkg::KIND_REFUSED;
    cmd.seq          = snd_seq;
    cmd.len          = '0;
    cmd.slot         = '0;
    cmd.cnt          = gbn_pkg::CNT_W'(1);

    if (window_we) begin
      win_limit_next = window_wdata;
    end

    if (accept) begin
      unique case (gbn_pkg::mode_t'(mode))
        gbn_pkg::MODE_OFFER: begin
          if (data_ended || fin_sent) begin
            push = 1'b1;
          end else if (chunk_len == '0) begin
            if (end_of_data) begin
              data_ended_next = 1'b1;
              if (outstanding == '0) begin
                push          = 1'b1;
                cmd.kind      = gbn_pkg::KIND_FIN;
                fin_sent_next = 1'b1;
              end
            end
          end else if (outstanding >= gbn_pkg::SEQ_W'(eff_window)) begin
            push = 1'b1;
          end else begin
            push           = 1'b1;
            cmd.op         = gbn_pkg::CMD_SEND;
            cmd.kind       = (snd_seq == '0) ? gbn_pkg::KIND_FIRST : gbn_pkg::KIND_DATA;
            cmd.len        = len_sat;
            cmd.slot       = gbn_pkg::SLOT_FIELD_W'(next_slot);
            snd_seq_next   = next_inc;
            next_slot_next = next_slot_inc;
            if (end_of_data) begin
              data_ended_next = 1'b1;
            end
          end
        end
        gbn_pkg::MODE_ACK: begin
          if (!fin_sent) begin
            if (ack_off < outstanding) begin
              base_upd       = ack_base;
              base_seq_next  = ack_base;
              base_slot_next = ack_slot;
            end
            if (data_ended && (snd_seq == base_upd)) begin
              push          = 1'b1;
              cmd.kind      = gbn_pkg::KIND_FIN;
              fin_sent_next = 1'b1;
            end
          end
        end
        gbn_pkg::MODE_TIMEOUT: begin
          if (outstanding != '0) begin
            push     = 1'b1;
            cmd.op   = gbn_pkg::CMD_RETX;
            cmd.kind = gbn_pkg::KIND_RETX;
            cmd.seq  = base_seq;
            cmd.slot = gbn_pkg::SLOT_FIELD_W'(base_slot);
            cmd.cnt  = outstanding[gbn_pkg::CNT_W-1:0];
          end
        end
        gbn_pkg::MODE_FIN_ACK: begin
          if (fin_sent) begin
            push     = 1'b1;
            cmd.kind = gbn_pkg::KIND_DONE;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win_limit   <= gbn_pkg::WIN_RESET;
      base_seq    <= '0;
      snd_seq     <= '0;
      base_slot   <= '0;
      next_slot   <= '0;
      data_ended  <= 1'b0;
      fin_sent    <= 1'b0;
    end else begin
      win_limit   <= win_limit_next;
      base_seq    <= base_seq_next;
      snd_seq     <= snd_seq_next;
      base_slot   <= base_slot_next;
      next_slot   <= next_slot_next;
      data_ended  <= data_ended_next;
      fin_sent    <= fin_sent_next;
    end
  end

endmodule

// File: hw/rtl/gbn_cmdq.sv
// ----------------------------------------------------------------------------
// gbn_cmdq
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module gbn_cmdq (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  gbn_pkg::cmd_t push_cmd,
  input  logic          pop,
  output logic          full,
  output logic          valid,
  output gbn_pkg::cmd_t head
);

  localparam int DEPTH = gbn_pkg::CMDQ_DEPTH;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_TOP = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_TOP = CW'(DEPTH);

  gbn_pkg::cmd_t  entries [DEPTH];
  logic [PW-1:0]  wr_ptr, rd_ptr;
  logic [CW-1:0]  count;
  logic           do_pop;

  assign full   = (count == CNT_TOP);
  assign valid  = (count != '0);
  assign head   = entries[rd_ptr];
  assign do_pop = pop && valid;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_TOP) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_TOP) ? '0 : rd_ptr + PW'(1);
      end
      priority if (push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

// File: hw/rtl/gbn_back.sv
// ----------------------------------------------------------------------------
// gbn_back
// Executes commands: records slot lengths and issues result items,
// walking the slot memory for retransmit runs.
// ----------------------------------------------------------------------------
module gbn_back #(
  parameter int SLOTS = gbn_pkg::DEF_SLOTS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             q_valid,
  input  gbn_pkg::cmd_t                    q_cmd,
  output logic                             pop,
  output logic                             strobe,
  output logic [gbn_pkg::KIND_W-1:0]       kind,
  output logic [gbn_pkg::SEQ_W-1:0]        seq_out,
  output logic [gbn_pkg::LEN_W-1:0]        len_out,
  output logic [gbn_pkg::SLOT_OUT_W-1:0]   slot_out,
  output logic                             last
);

  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [SW-1:0] SLOT_TOP = SW'(SLOTS - 1);

  logic [gbn_pkg::LEN_W-1:0] slot_mem [SLOTS];
  logic [gbn_pkg::LEN_W-1:0] rd_data;

  logic                      run_active, run_active_next;
  logic [gbn_pkg::SEQ_W-1:0] run_seq, run_seq_next;
  logic [SW-1:0]             run_slot, run_slot_next;
  logic [gbn_pkg::CNT_W-1:0] run_left, run_left_next;

  logic                      issue;
  logic                      wr_en;
  gbn_pkg::kind_t            iss_kind;
  logic [gbn_pkg::SEQ_W-1:0] iss_seq;
  logic [SW-1:0]             iss_slot;
  logic [gbn_pkg::LEN_W-1:0] iss_len;
  logic                      iss_use_mem;
  logic                      iss_last;
  logic [gbn_pkg::CNT_W-1:0] iss_left;
  logic [gbn_pkg::SEQ_W-1:0] seq_inc;
  logic [SW-1:0]             slot_inc;
  logic [gbn_pkg::SLOT_FIELD_W-1:0] slot_wide;

  logic                      o_valid;
  gbn_pkg::kind_t            o_kind;
  logic [gbn_pkg::SEQ_W-1:0] o_seq;
  logic [gbn_pkg::LEN_W-1:0] o_len;
  logic                      o_use_mem;
  logic [gbn_pkg::SLOT_OUT_W-1:0] o_slot;
  logic                      o_last;

  always_comb begin
    pop             = 1'b0;
    issue           = 1'b0;
    wr_en           = 1'b0;
    iss_kind        = q_cmd.kind;
    iss_seq         = q_cmd.seq;
    iss_slot        = q_cmd.slot[SW-1:0];
    iss_len         = '0;
    iss_use_mem     = 1'b0;
    iss_last        = 1'b1;
    iss_left        = q_cmd.cnt;
    run_active_next = run_active;
    run_left_next   = run_left;

    if (run_active) begin
      issue       = 1'b1;
      iss_kind    = gbn_pkg::KIND_RETX;
      iss_seq     = run_seq;
      iss_slot    = run_slot;
      iss_use_mem = 1'b1;
      iss_left    = run_left;
    end else if (q_valid) begin
      pop   = 1'b1;
      issue = 1'b1;
      unique case (q_cmd.op)
        gbn_pkg::CMD_SEND: begin
          wr_en   = 1'b1;
          iss_len = q_cmd.len;
        end
        gbn_pkg::CMD_RETX: begin
          iss_use_mem = 1'b1;
        end
        default: begin
          iss_slot = '0;
        end
      endcase
    end

    // retransmit runs walk one slot per cycle
    if (iss_use_mem) begin
      iss_last        = (iss_left == gbn_pkg::CNT_W'(1));
      run_active_next = !iss_last;
      run_left_next   = iss_left - gbn_pkg::CNT_W'(1);
    end

    seq_inc = iss_seq + gbn_pkg::SEQ_W'(1);
    if (seq_inc == '0 || iss_slot == SLOT_TOP) begin
      slot_inc = '0;
    end else begin
      slot_inc = iss_slot + SW'(1);
    end
    run_seq_next  = seq_inc;
    run_slot_next = slot_inc;
    slot_wide     = gbn_pkg::SLOT_FIELD_W'(iss_slot);
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_mem[iss_slot] <= iss_len;
    end
    rd_data <= slot_mem[iss_slot];
  end

  always_ff @(posedge clk) begin
    o_kind    <= iss_kind;
    o_seq     <= iss_seq;
    o_len     <= iss_len;
    o_use_mem <= iss_use_mem;
    o_slot    <= slot_wide[gbn_pkg::SLOT_OUT_W-1:0];
    o_last    <= iss_last;
    run_seq   <= run_seq_next;
    run_slot  <= run_slot_next;
    run_left  <= run_left_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid    <= 1'b0;
      run_active <= 1'b0;
    end else begin
      o_valid    <= issue;
      run_active <= run_active_next;
    end
  end

  assign strobe   = o_valid;
  assign kind     = o_kind;
  assign seq_out  = o_seq;
  assign len_out  = o_use_mem ? rd_data : o_len;
  assign slot_out = o_slot;
  assign last     = o_last;

endmodule
